// ===== hw/rtl/bkm_pkg.sv =====
// Shared definitions for the binary keying modulator: defaults, register
// indexes, queue depth and the quarter-wave sine table generator.
// No dependencies.
package bkm_pkg;

  // Default build parameters
  localparam int unsigned PHASE_BITS_DEF      = 32;
  localparam int unsigned TABLE_ADDR_BITS_DEF = 8;
  localparam int unsigned SAMPLE_BITS_DEF     = 16;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_CARRIER_STEP   = 2'd0,
    REG_TONE_ZERO_STEP = 2'd1,
    REG_TONE_ONE_STEP  = 2'd2
  } cfg_reg_t;

  localparam logic [CFG_DATA_W-1:0] CARRIER_STEP_RST   = 32'd53687091;
  localparam logic [CFG_DATA_W-1:0] TONE_ZERO_STEP_RST = 32'd80530637;
  localparam logic [CFG_DATA_W-1:0] TONE_ONE_STEP_RST  = 32'd107374182;

  // Input beat: data bit in bit 0, padded to a byte
  localparam int unsigned IN_TDATA_W = 8;

  // Depth of the queue between front and back (power of two)
  localparam int unsigned FIFO_DEPTH = 4;

  // pi/2 in Q2.30 and the Taylor divisors 2n(2n+1) for n = 1..8
  localparam longint unsigned HALFPI_Q30 = 64'd1686629713;
  localparam longint unsigned TAYLOR_DIV [8] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
  };

  // Quarter-wave entry k of a table with 2^addr_bits steps, amplitude smax.
  // Evaluated at elaboration only.
  function automatic longint sine_entry(input int unsigned k,
                                        input int unsigned addr_bits,
                                        input longint smax);
    longint unsigned x;
    longint unsigned term;
    longint sum;
    longint v;
    x = (HALFPI_Q30 * longint'(k)) >> addr_bits;
    term = x;
    sum = longint'(x);
    for (int n = 1; n <= 8; n++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = term / TAYLOR_DIV[n-1];
      if (n[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) sum = 0;
    if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
    v = (sum * smax + (64'sd1 <<< 29)) >>> 30;
    if (v > smax) v = smax;
    return v;
  endfunction

endpackage

// ===== hw/rtl/bkm_fifo.sv =====
// Short register queue that decouples the front (phase tracking) from the
// back (table lookup and keying). Does not use bkm_pkg; its caller picks the
// depth; generic in width and depth.
module bkm_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

// ===== hw/rtl/bkm_front.sv =====
// Front end: step registers, three phase accumulators, and folding of the
// carrier and selected tone phase into quarter-table index plus sign.
// Depends on bkm_pkg.
module bkm_front #(
  parameter int unsigned PHASE_BITS      = bkm_pkg::PHASE_BITS_DEF,
  parameter int unsigned TABLE_ADDR_BITS = bkm_pkg::TABLE_ADDR_BITS_DEF,
  parameter int unsigned ENTRY_W         = 2 * (TABLE_ADDR_BITS + 1) + 3
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bkm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [bkm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_bit,
  output logic                            push_valid,
  input  logic                            push_ready,
  output logic [ENTRY_W-1:0]              push_data
);

  localparam int unsigned A = TABLE_ADDR_BITS;

  logic [bkm_pkg::CFG_DATA_W-1:0] carrier_step_r, tone_zero_step_r, tone_one_step_r;
  logic [PHASE_BITS-1:0] carrier_ph_r, carrier_ph_nxt;
  logic [PHASE_BITS-1:0] zero_ph_r, zero_ph_nxt;
  logic [PHASE_BITS-1:0] one_ph_r, one_ph_nxt;
  logic [A+1:0]          c_fold, f_fold;
  logic                  accept;

  // Top A+2 phase bits -> {negate, folded index of A+1 bits}
  function automatic logic [A+1:0] fold(input logic [PHASE_BITS-1:0] ph);
    logic [A+1:0] top_bits;
    logic [A:0]   idx;
    top_bits = ph[PHASE_BITS-1 -: A+2];
    idx = {1'b0, top_bits[A-1:0]};
    if (top_bits[A]) idx = {1'b1, {A{1'b0}}} - idx;
    return {top_bits[A+1], idx};
  endfunction

  // Step registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carrier_step_r   <= bkm_pkg::CARRIER_STEP_RST;
      tone_zero_step_r <= bkm_pkg::TONE_ZERO_STEP_RST;
      tone_one_step_r  <= bkm_pkg::TONE_ONE_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        bkm_pkg::REG_CARRIER_STEP:   carrier_step_r   <= cfg_wdata;
        bkm_pkg::REG_TONE_ZERO_STEP: tone_zero_step_r <= cfg_wdata;
        bkm_pkg::REG_TONE_ONE_STEP:  tone_one_step_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid & push_ready;

  // Samples use the phases as they stand before this beat
  assign c_fold = fold(carrier_ph_r);
  assign f_fold = fold(in_bit ? one_ph_r : zero_ph_r);

  // Entry: bit, carrier sign, tone sign, carrier index, tone index
  assign push_data = {f_fold[A:0], c_fold[A:0], f_fold[A+1], c_fold[A+1], in_bit};

  // Phase accumulators, modulo 2^PHASE_BITS
  always_comb begin
    carrier_ph_nxt = carrier_ph_r;
    zero_ph_nxt    = zero_ph_r;
    one_ph_nxt     = one_ph_r;
    if (accept) begin
      carrier_ph_nxt = carrier_ph_r + PHASE_BITS'(carrier_step_r);
      zero_ph_nxt    = zero_ph_r + PHASE_BITS'(tone_zero_step_r);
      one_ph_nxt     = one_ph_r + PHASE_BITS'(tone_one_step_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carrier_ph_r <= '0;
      zero_ph_r    <= '0;
      one_ph_r     <= '0;
    end else begin
      carrier_ph_r <= carrier_ph_nxt;
      zero_ph_r    <= zero_ph_nxt;
      one_ph_r     <= one_ph_nxt;
    end
  end

endmodule

// ===== hw/rtl/bkm_back.sv =====
// Back end: quarter-wave table lookup (registered), then ASK/PSK/FSK keying
// into the output register. Depends on bkm_pkg for the table generator.
module bkm_back #(
  parameter int unsigned TABLE_ADDR_BITS = bkm_pkg::TABLE_ADDR_BITS_DEF,
  parameter int unsigned SAMPLE_BITS     = bkm_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned ENTRY_W         = 2 * (TABLE_ADDR_BITS + 1) + 3
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   pop_valid,
  output logic                   pop_ready,
  input  logic [ENTRY_W-1:0]     pop_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] ask,
  output logic [SAMPLE_BITS-1:0] psk,
  output logic [SAMPLE_BITS-1:0] fsk
);

  localparam int unsigned A     = TABLE_ADDR_BITS;
  localparam int unsigned TBL_N = (1 << A) + 1;
  localparam longint      SMAX  = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;

  logic [SAMPLE_BITS-1:0] qtab [TBL_N];

  // Quarter-wave table, constant
  for (genvar k = 0; k < TBL_N; k++) begin : g_tab
    assign qtab[k] = SAMPLE_BITS'(bkm_pkg::sine_entry(k, A, SMAX));
  end

  logic                   s1_valid_r, s1_valid_nxt;
  logic                   s1_bit_r, s1_cneg_r, s1_fneg_r;
  logic [SAMPLE_BITS-1:0] s1_cmag_r, s1_fmag_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0] ask_r, psk_r, fsk_r;
  logic [SAMPLE_BITS-1:0] ask_nxt, psk_nxt, fsk_nxt;
  logic [SAMPLE_BITS-1:0] c_sgn, c_half, half_sgn;
  logic [A:0]             c_idx, f_idx;
  logic                   s1_adv, s1_load;

  assign c_idx = pop_data[3 +: A+1];
  assign f_idx = pop_data[4+A +: A+1];

  // Pipeline flow: output register frees stage 1, stage 1 frees the queue
  assign s1_adv    = ~out_valid_r | out_ready;
  assign pop_ready = ~s1_valid_r | s1_adv;
  assign s1_load   = pop_valid & pop_ready;

  always_comb begin
    s1_valid_nxt  = pop_ready ? pop_valid : s1_valid_r;
    out_valid_nxt = s1_adv ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Stage 1: table read
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_bit_r  <= pop_data[0];
      s1_cneg_r <= pop_data[1];
      s1_fneg_r <= pop_data[2];
      s1_cmag_r <= qtab[c_idx];
      s1_fmag_r <= qtab[f_idx];
    end
  end

  // Keying; half amplitude rounds half away from zero
  always_comb begin
    c_sgn    = s1_cneg_r ? SAMPLE_BITS'(-s1_cmag_r) : s1_cmag_r;
    c_half   = (s1_cmag_r + 1'b1) >> 1;
    half_sgn = s1_cneg_r ? SAMPLE_BITS'(-c_half) : c_half;
    ask_nxt  = s1_bit_r ? c_sgn : half_sgn;
    psk_nxt  = (s1_cneg_r ^ s1_bit_r) ? SAMPLE_BITS'(-s1_cmag_r) : s1_cmag_r;
    fsk_nxt  = s1_fneg_r ? SAMPLE_BITS'(-s1_fmag_r) : s1_fmag_r;
  end

  // Stage 2: output register
  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      ask_r <= ask_nxt;
      psk_r <= psk_nxt;
      fsk_r <= fsk_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign ask       = ask_r;
  assign psk       = psk_r;
  assign fsk       = fsk_r;

endmodule

// ===== hw/rtl/binary_keying_modulator.sv =====
// Top level of the binary ASK/PSK/FSK modulator: front, queue and back.
// Depends on bkm_pkg, bkm_front, bkm_fifo and bkm_back.
//
//   channel  dir  beat contents (low bit first)
//   in_      in   tdata: data_bit, zero pad to a byte
//   out_     out  tdata: ask_sample, psk_sample, fsk_sample (SAMPLE_BITS each),
//                 zero pad to whole bytes
//   cfg_     in   write: index 0 carrier_step, 1 tone_zero_step, 2 tone_one_step
//
// One beat per clock sustained in both directions while out_tready stays high.
// An accepted beat passes through the queue, the registered table read and
// the output register on its way to the output. Reset is synchronous;
// it zeroes the phases and loads the default steps. An output stall fills
// the back pipeline and then the four-entry queue before in_tready drops.
module binary_keying_modulator #(
  parameter int unsigned PHASE_BITS      = bkm_pkg::PHASE_BITS_DEF,
  parameter int unsigned TABLE_ADDR_BITS = bkm_pkg::TABLE_ADDR_BITS_DEF,
  parameter int unsigned SAMPLE_BITS     = bkm_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned OUT_TDATA_W     = ((3 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration
  input  logic                            cfg_we,
  input  logic [bkm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [bkm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // Input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bkm_pkg::IN_TDATA_W-1:0]  in_tdata,   // [0] data_bit
  // Output stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [OUT_TDATA_W-1:0]          out_tdata   // ask, psk, fsk from bit 0
);

  localparam int unsigned ENTRY_W = 2 * (TABLE_ADDR_BITS + 1) + 3;

  logic               push_valid, push_ready;
  logic [ENTRY_W-1:0] push_data;
  logic               pop_valid, pop_ready;
  logic [ENTRY_W-1:0] pop_data;
  logic [SAMPLE_BITS-1:0] ask, psk, fsk;

  bkm_front #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .ENTRY_W         (ENTRY_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_bit     (in_tdata[0]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  bkm_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (bkm_pkg::FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  bkm_back #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .SAMPLE_BITS     (SAMPLE_BITS),
    .ENTRY_W         (ENTRY_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .ask       (ask),
    .psk       (psk),
    .fsk       (fsk)
  );

  assign out_tdata = OUT_TDATA_W'({fsk, psk, ask});

endmodule
